// ===== hdl/dlmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Dense layer package
// Types and codes shared by the dense layer front end, queue and datapath.
// ----------------------------------------------------------------------------
package dlmb_pkg;

    localparam int VALUE_W     = 40;
    localparam int IDX_W       = 3;
    localparam int ELEM_W      = 16;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // Item kinds, also used as command codes in the queue.
    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_INPUT   = 2'd1;
    localparam logic [1:0] KIND_BIAS    = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_OUT  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [ELEM_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last;
    } result_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } cmd_t;

    // Matrix dimensions, already limited to the store size.
    typedef struct packed {
        logic [DIM_W-1:0] rows_out;
        logic [DIM_W-1:0] inner_len;
        logic [DIM_W-1:0] cols_out;
    } dims_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hdl/dlmb_front.sv =====
// ----------------------------------------------------------------------------
// Dense layer front end
// Accepts input words, drops loads that fall outside the stores and turns
// the rest into queue commands.
// ----------------------------------------------------------------------------
module dlmb_front
    import dlmb_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  q_full,
    output logic  push,
    output cmd_t  cmd
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok = (32'(item.row_index) < 32'(MAX_DIM));
    assign col_ok = (32'(item.col_index) < 32'(MAX_DIM));

    always_comb
    begin
        if (item.kind inside {KIND_WEIGHT, KIND_INPUT})
        begin
            keep = row_ok && col_ok;
        end
        else if (item.kind == KIND_BIAS)
        begin
            keep = col_ok;
        end
        else
        begin
            keep = 1'b1;
        end
    end

    assign item_ready = !q_full;
    assign push       = item_valid && item_ready && keep;

    assign cmd.kind  = item.kind;
    assign cmd.row   = item.row_index;
    assign cmd.col   = item.col_index;
    assign cmd.value = item.element_value;

endmodule

// ===== hdl/dlmb_fifo.sv =====
// ----------------------------------------------------------------------------
// Dense layer command queue
// A short first-in first-out queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module dlmb_fifo
    import dlmb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== hdl/dlmb_back.sv =====
// ----------------------------------------------------------------------------
// Dense layer datapath
// Holds the weight, input and bias stores, carries out loads and runs the
// multiply-accumulate pipeline for compute commands.
// ----------------------------------------------------------------------------
module dlmb_back
    import dlmb_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  dims_t   dims,
    input  logic    q_empty,
    input  cmd_t    head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int ENT = MAX_DIM * MAX_DIM;
    localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PW  = 2 * DATA_WIDTH;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    typedef struct packed {
        logic             first;
        logic             last_elem;
        logic             last_run;
        logic             mul_on;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    logic signed [DATA_WIDTH-1:0] w_mem [ENT];
    logic signed [DATA_WIDTH-1:0] x_mem [ENT];
    logic signed [DATA_WIDTH-1:0] b_mem [MAX_DIM];

    logic [0:0]    state_reg;
    logic [0:0]    state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] nr_last_reg, nr_last_next;
    logic [IW-1:0] nc_last_reg, nc_last_next;
    logic [IW-1:0] nk_last_reg, nk_last_next;
    logic          nk_zero_reg, nk_zero_next;

    logic                         adv;
    logic                         issue;
    logic                         k_last;
    logic                         j_last;
    logic                         i_last;
    logic                         start;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                w_addr;
    logic [AW-1:0]                x_addr;
    logic signed [DATA_WIDTH-1:0] wr_val;

    logic                         s1_valid_reg;
    tag_t                         s1_tag_reg;
    logic signed [DATA_WIDTH-1:0] w_rd_reg;
    logic signed [DATA_WIDTH-1:0] x_rd_reg;
    logic signed [DATA_WIDTH-1:0] b_rd_reg;

    logic                         s2_valid_reg;
    tag_t                         s2_tag_reg;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         prod_reg;
    logic signed [DATA_WIDTH-1:0] b2_reg;

    logic signed [VALUE_W-1:0]    acc_reg;
    logic signed [VALUE_W-1:0]    acc_next;
    logic                         result_valid_reg;
    result_t                      result_reg;

    // The whole pipeline holds while a finished word waits at the output.
    assign adv   = !result_valid_reg || result_ready;
    assign issue = (state_reg == ST_RUN) && adv;
    assign pop   = (state_reg == ST_IDLE) && !q_empty;
    assign start = pop && (head.kind == KIND_COMPUTE)
                   && (dims.rows_out != '0) && (dims.cols_out != '0);

    assign k_last = nk_zero_reg || (k_reg == nk_last_reg);
    assign j_last = (j_reg == nc_last_reg);
    assign i_last = (i_reg == nr_last_reg);

    // ---------------- Loads ----------------
    assign wr_val  = DATA_WIDTH'(head.value);
    assign wr_addr = AW'(32'(head.row) * 32'(MAX_DIM) + 32'(head.col));

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_WEIGHT)
        begin
            w_mem[wr_addr] <= wr_val;
        end
        if (pop && head.kind == KIND_INPUT)
        begin
            x_mem[wr_addr] <= wr_val;
        end
        if (pop && head.kind == KIND_BIAS)
        begin
            b_mem[IW'(head.col)] <= wr_val;
        end
    end

    // ---------------- Sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        nr_last_next = nr_last_reg;
        nc_last_next = nc_last_reg;
        nk_last_next = nk_last_reg;
        nk_zero_next = nk_zero_reg;
        if (start)
        begin
            state_next   = ST_RUN;
            i_next       = '0;
            j_next       = '0;
            k_next       = '0;
            nr_last_next = IW'(dims.rows_out - 1'b1);
            nc_last_next = IW'(dims.cols_out - 1'b1);
            nk_last_next = IW'(dims.inner_len - 1'b1);
            nk_zero_next = (dims.inner_len == '0);
        end
        else if (issue)
        begin
            if (!k_last)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                k_next = '0;
                if (!j_last)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    j_next = '0;
                    if (!i_last)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            nr_last_reg <= '0;
            nc_last_reg <= '0;
            nk_last_reg <= '0;
            nk_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            nr_last_reg <= nr_last_next;
            nc_last_reg <= nc_last_next;
            nk_last_reg <= nk_last_next;
            nk_zero_reg <= nk_zero_next;
        end
    end

    // ---------------- Stage 1: store reads ----------------
    assign w_addr = AW'(32'(i_reg) * 32'(MAX_DIM) + 32'(k_reg));
    assign x_addr = AW'(32'(k_reg) * 32'(MAX_DIM) + 32'(j_reg));

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            w_rd_reg             <= w_mem[w_addr];
            x_rd_reg             <= x_mem[x_addr];
            b_rd_reg             <= b_mem[j_reg];
            s1_tag_reg.first     <= (k_reg == '0);
            s1_tag_reg.last_elem <= k_last;
            s1_tag_reg.last_run  <= k_last && j_last && i_last;
            s1_tag_reg.mul_on    <= !nk_zero_reg;
            s1_tag_reg.row       <= IDX_W'(i_reg);
            s1_tag_reg.col       <= IDX_W'(j_reg);
        end
    end

    // ---------------- Stage 2: multiply ----------------
    assign prod = PW'(w_rd_reg) * PW'(x_rd_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= s1_tag_reg.mul_on ? prod : '0;
            b2_reg     <= b_rd_reg;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // ---------------- Stage 3: accumulate ----------------
    always_comb
    begin
        if (s2_tag_reg.first)
        begin
            acc_next = VALUE_W'(b2_reg) + VALUE_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + VALUE_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            acc_reg <= acc_next;
            if (s2_tag_reg.last_elem)
            begin
                result_reg.out_row   <= s2_tag_reg.row;
                result_reg.out_col   <= s2_tag_reg.col;
                result_reg.out_value <= acc_next;
                result_reg.last      <= s2_tag_reg.last_run;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_tag_reg.last_elem;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/dense_layer_matmul_bias.sv =====
// ----------------------------------------------------------------------------
// Dense layer: matrix multiply with bias add
// Loads weights, inputs and biases word by word and, on a compute word,
// streams out every element of weights times inputs plus column bias.
//
//   Channel   Signals                              Direction
//   config    cfg_we, cfg_index, cfg_data          in, write only
//   item      item_valid, item_ready, item         in
//   result    result_valid, result_ready, result   out
//
// The front end takes one word per cycle while the four-entry queue has room.
// A load leaves the queue while the datapath is idle. A compute word leaves the queue
// and then occupies the datapath for rows_out * cols_out * max(inner_len, 1)
// multiplies, one per cycle unless a result word waits, with dimensions after
// saturation; its last result then comes through the multiply and accumulate stages.
// Reset sets all three dimensions to 8; the stores hold nothing defined.
// A result word that is not taken holds the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module dense_layer_matmul_bias
    import dlmb_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] rows_out_reg;
    logic [DIM_W-1:0] inner_len_reg;
    logic [DIM_W-1:0] cols_out_reg;
    dims_t            dims;
    logic             push;
    logic             pop;
    cmd_t             push_cmd;
    cmd_t             head;
    q_stat_t          q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_out_reg  <= 4'd8;
            inner_len_reg <= 4'd8;
            cols_out_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_OUT:  rows_out_reg  <= cfg_data;
                CFG_INNER_LEN: inner_len_reg <= cfg_data;
                CFG_COLS_OUT:  cols_out_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Dimensions beyond the store size are cut back to it.
    assign dims.rows_out  = (rows_out_reg > DIM_LIMIT) ? DIM_LIMIT : rows_out_reg;
    assign dims.inner_len = (inner_len_reg > DIM_LIMIT) ? DIM_LIMIT : inner_len_reg;
    assign dims.cols_out  = (cols_out_reg > DIM_LIMIT) ? DIM_LIMIT : cols_out_reg;

    dlmb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_stat.full),
        .push       (push),
        .cmd        (push_cmd)
    );

    dlmb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    dlmb_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .q_empty      (q_stat.empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue written while full");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");
`endif

endmodule
